// ----- src/page_framebuffer_dirty_tiles_macros.svh -----
// Assertion macros shared by the checker of the page framebuffer block.
// Depends on nothing; the user supplies i_clk and i_rst_n in scope.
`ifndef PAGE_FRAMEBUFFER_DIRTY_TILES_MACROS_SVH
`define PAGE_FRAMEBUFFER_DIRTY_TILES_MACROS_SVH
// Same-cycle implication, disabled while reset is held.
`define PFDT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define PFDT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- src/pfdt_pkg.sv -----
`timescale 1ns / 1ps
// Package of the page framebuffer block: codes, command word and status structs.
// Depends on nothing.
package pfdt_pkg;

    localparam int QDEPTH = 2;
    localparam logic [7:0] MAX_TILES = 8'd8;
    localparam logic [7:0] TILED_LIMIT_RST = 8'd8;

    localparam logic REG_HEADLESS = 1'b0;
    localparam logic REG_TLIMIT   = 1'b1;

    localparam logic [2:0] OP_PIXEL = 3'd0;
    localparam logic [2:0] OP_HLINE = 3'd1;
    localparam logic [2:0] OP_VLINE = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_RECT  = 3'd4;
    localparam logic [2:0] OP_FLUSH = 3'd5;

    localparam logic [1:0] COL_BLACK  = 2'd0;
    localparam logic [1:0] COL_WHITE  = 2'd1;
    localparam logic [1:0] COL_INVERT = 2'd2;
    localparam logic [1:0] COL_BAD    = 2'd3;

    typedef enum logic [1:0] {KIND_STATUS, KIND_TILE, KIND_FULL} t_kind;
    typedef enum logic [1:0] {ST_OK, ST_OOB, ST_COLOR} t_status;
    typedef enum logic [2:0] {CMD_STATUS, CMD_DRAW, CMD_CLEAR, CMD_RECT, CMD_FLUSH} t_cmd_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_RD, S_WR, S_CNT, S_DECIDE, S_TSCAN, S_TRD, S_TEMIT
    } t_bk_state;

    typedef struct packed {
        t_cmd_kind   kind;
        t_status     status;
        logic        vert;
        logic [7:0]  fixed;
        logic [7:0]  start;
        logic [7:0]  stop;
        logic [1:0]  color;
        logic [4:0]  c0;
        logic [4:0]  c1;
        logic [4:0]  r0;
        logic [4:0]  r1;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic init;
    } t_bk_stat;

endpackage

// ----- src/page_framebuffer_dirty_tiles.sv -----
`timescale 1ns / 1ps
// Pixel and line commands read then write each pixel in turn; clear zeroes every byte.
// Flush counts dirty tiles by column, then sends each one, or a full word above the limit.
// Commands pass through a two-word queue; busy rises when the queue is full or during the reset clear.
// After reset a clearing pass over WIDTH_PX*PAGES bytes (1024 by default) holds busy high.
// Results are strobed for one cycle and the receiver cannot stall them.
module page_framebuffer_dirty_tiles #(
    parameter int WIDTH_PX  = 128,
    parameter int HEIGHT_PX = 64,
    parameter int TILE_COLS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_x_a,
    input  logic [7:0]  i_y_a,
    input  logic [7:0]  i_x_b,
    input  logic [7:0]  i_y_b,
    input  logic [7:0]  i_rect_width,
    input  logic [7:0]  i_rect_height,
    input  logic [1:0]  i_color,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [3:0]  o_tile_col,
    output logic [2:0]  o_tile_row,
    output logic [63:0] o_tile_data,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfdt_pkg::*;

    logic       r_headless;
    logic [7:0] r_tlimit;
    logic       push, pop;
    t_cmd       fe_cmd, q_cmd;
    t_q_stat    q_stat;
    t_bk_stat   bk_stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TLIMIT) ? {24'd0, r_tlimit} : {31'd0, r_headless};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_headless <= 1'b0;
            r_tlimit <= TILED_LIMIT_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_HEADLESS) begin
                r_headless <= pwdata[0];
            end else begin
                r_tlimit <= pwdata[7:0];
            end
        end
    end

    pfdt_front #(.WIDTH_PX(WIDTH_PX), .HEIGHT_PX(HEIGHT_PX)) u_front (
        .i_start(start), .o_busy(busy), .i_op(i_op), .i_x_a(i_x_a), .i_y_a(i_y_a),
        .i_x_b(i_x_b), .i_y_b(i_y_b), .i_rect_width(i_rect_width),
        .i_rect_height(i_rect_height), .i_color(i_color), .i_headless(r_headless),
        .i_q(q_stat), .i_bk(bk_stat), .o_push(push), .o_cmd(fe_cmd)
    );

    pfdt_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(fe_cmd),
        .i_pop(pop), .o_data(q_cmd), .o_stat(q_stat)
    );

    pfdt_back #(.WIDTH_PX(WIDTH_PX), .HEIGHT_PX(HEIGHT_PX), .TILE_COLS(TILE_COLS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(q_cmd), .i_q(q_stat), .o_pop(pop),
        .i_tiled_limit(r_tlimit), .o_stat(bk_stat), .o_valid(o_valid), .o_kind(o_kind),
        .o_status(o_status), .o_tile_col(o_tile_col), .o_tile_row(o_tile_row),
        .o_tile_data(o_tile_data), .o_last(o_last)
    );

endmodule

// ----- src/pfdt_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts command words, checks bounds and colour, builds queue entries.
// Depends on pfdt_pkg.
module pfdt_front #(
    parameter int WIDTH_PX  = 128,
    parameter int HEIGHT_PX = 64
) (
    input  logic              i_start,
    output logic              o_busy,
    input  logic [2:0]        i_op,
    input  logic [7:0]        i_x_a,
    input  logic [7:0]        i_y_a,
    input  logic [7:0]        i_x_b,
    input  logic [7:0]        i_y_b,
    input  logic [7:0]        i_rect_width,
    input  logic [7:0]        i_rect_height,
    input  logic [1:0]        i_color,
    input  logic              i_headless,
    input  pfdt_pkg::t_q_stat i_q,
    input  pfdt_pkg::t_bk_stat i_bk,
    output logic              o_push,
    output pfdt_pkg::t_cmd    o_cmd
);
    import pfdt_pkg::*;

    localparam logic [8:0] WLIM = 9'(WIDTH_PX);
    localparam logic [8:0] HLIM = 9'(HEIGHT_PX);
    localparam logic [7:0] WMAX = 8'(WIDTH_PX - 1);
    localparam logic [7:0] HMAX = 8'(HEIGHT_PX - 1);

    logic [7:0] lo_x, hi_x, lo_y, hi_y, xend, yend;

    assign o_busy = i_q.full || i_bk.init;
    assign o_push = i_start && !o_busy;

    assign lo_x = (i_x_a > i_x_b) ? i_x_b : i_x_a;
    assign hi_x = (i_x_a > i_x_b) ? i_x_a : i_x_b;
    assign lo_y = (i_y_a > i_y_b) ? i_y_b : i_y_a;
    assign hi_y = (i_y_a > i_y_b) ? i_y_a : i_y_b;
    assign xend = i_x_a + i_rect_width - 8'd1;
    assign yend = i_y_a + i_rect_height - 8'd1;

    always_comb begin
        o_cmd = '0;
        o_cmd.kind = CMD_STATUS;
        o_cmd.status = ST_OK;
        o_cmd.color = i_color;
        if (!i_headless) begin
            unique case (i_op)
                OP_PIXEL: begin
                    if ({1'b0, i_x_a} >= WLIM || {1'b0, i_y_a} >= HLIM) begin
                        o_cmd.status = ST_OOB;
                    end else if (i_color == COL_BAD) begin
                        o_cmd.status = ST_COLOR;
                    end else begin
                        o_cmd.kind = CMD_DRAW;
                        o_cmd.fixed = i_y_a;
                        o_cmd.start = i_x_a;
                        o_cmd.stop = i_x_a;
                    end
                end
                OP_HLINE: begin
                    if ({1'b0, i_y_a} >= HLIM) begin
                        o_cmd.status = ST_OOB;
                    end else if (i_color != COL_BAD && {1'b0, lo_x} < WLIM) begin
                        o_cmd.kind = CMD_DRAW;
                        o_cmd.fixed = i_y_a;
                        o_cmd.start = lo_x;
                        o_cmd.stop = (hi_x > WMAX) ? WMAX : hi_x;
                    end
                end
                OP_VLINE: begin
                    if ({1'b0, i_x_a} >= WLIM) begin
                        o_cmd.status = ST_OOB;
                    end else if (i_color != COL_BAD && {1'b0, lo_y} < HLIM) begin
                        o_cmd.kind = CMD_DRAW;
                        o_cmd.vert = 1'b1;
                        o_cmd.fixed = i_x_a;
                        o_cmd.start = lo_y;
                        o_cmd.stop = (hi_y > HMAX) ? HMAX : hi_y;
                    end
                end
                OP_CLEAR: o_cmd.kind = CMD_CLEAR;
                OP_RECT: begin
                    if (i_rect_width != 8'd0 && i_rect_height != 8'd0) begin
                        o_cmd.kind = CMD_RECT;
                        o_cmd.c0 = i_x_a[7:3];
                        o_cmd.c1 = xend[7:3];
                        o_cmd.r0 = i_y_a[7:3];
                        o_cmd.r1 = yend[7:3];
                    end
                end
                OP_FLUSH: o_cmd.kind = CMD_FLUSH;
                default: o_cmd.kind = CMD_STATUS;
            endcase
        end
    end

endmodule

// ----- src/pfdt_fifo.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on pfdt_pkg.
module pfdt_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pfdt_pkg::t_cmd    i_data,
    input  logic              i_pop,
    output pfdt_pkg::t_cmd    o_data,
    output pfdt_pkg::t_q_stat o_stat
);
    import pfdt_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_cmd            r_mem [QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_data = r_mem[r_rp];
    assign o_stat.full = (r_cnt == CW'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- src/pfdt_back.sv -----
`timescale 1ns / 1ps
// Back end: framebuffer memory, dirty bitmap and the sequencer that draws and flushes.
// Depends on pfdt_pkg.
module pfdt_back #(
    parameter int WIDTH_PX  = 128,
    parameter int HEIGHT_PX = 64,
    parameter int TILE_COLS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfdt_pkg::t_cmd     i_cmd,
    input  pfdt_pkg::t_q_stat  i_q,
    output logic               o_pop,
    input  logic [7:0]         i_tiled_limit,
    output pfdt_pkg::t_bk_stat o_stat,
    output logic               o_valid,
    output logic [1:0]         o_kind,
    output logic [1:0]         o_status,
    output logic [3:0]         o_tile_col,
    output logic [2:0]         o_tile_row,
    output logic [63:0]        o_tile_data,
    output logic               o_last
);
    import pfdt_pkg::*;

    localparam int PAGES    = (HEIGHT_PX + 7) / 8;
    localparam int FB_BYTES = WIDTH_PX * PAGES;
    localparam int AW       = $clog2(FB_BYTES);
    localparam int NT       = TILE_COLS * 8;
    localparam int TW       = $clog2(NT + 1);
    localparam int CCW      = $clog2(TILE_COLS + 1);

    t_bk_state       r_state, n_state;
    t_cmd            r_cmd;
    logic [7:0]      r_cur;
    logic [AW-1:0]   r_addr;
    logic            r_init;
    logic [NT-1:0]   r_dirty, r_scan;
    logic            r_any;
    logic [7:0]      r_cnt;
    logic [CCW-1:0]  r_ccol;
    logic [TW-1:0]   r_tidx;
    logic [3:0]      r_emit;
    logic [3:0]      r_byte;
    logic            r_prev_ok;
    logic [63:0]     r_tile;
    logic [7:0]      mem [FB_BYTES];
    logic [7:0]      r_rdata;

    logic            n_valid, n_last;
    logic [1:0]      n_kind, n_status;
    logic [3:0]      n_col;
    logic [2:0]      n_row;
    logic [63:0]     n_data;

    logic [7:0]      px_x, px_y, px_bit, px_new;
    logic [AW-1:0]   px_addr, t_addr;
    logic [31:0]     t_x, t_row;
    logic            t_ok, tiled, tile_last;
    logic [7:0]      lim;
    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [7:0]      mem_wdata;

    function automatic logic [NT-1:0] mark_mask(input logic [4:0] c0, input logic [4:0] c1,
                                                input logic [4:0] r0, input logic [4:0] r1);
        logic [NT-1:0] m;
        m = '0;
        for (int c = 0; c < TILE_COLS; c++) begin
            for (int r = 0; r < 8; r++) begin
                m[c*8+r] = (5'(c) >= c0) && (5'(c) <= c1) && (5'(r) >= r0) && (5'(r) <= r1);
            end
        end
        return m;
    endfunction

    assign px_x = r_cmd.vert ? r_cmd.fixed : r_cur;
    assign px_y = r_cmd.vert ? r_cur : r_cmd.fixed;
    assign px_addr = AW'(32'(px_y[7:3]) * WIDTH_PX + 32'(px_x));
    assign px_bit = 8'd1 << px_y[2:0];

    always_comb begin
        case (r_cmd.color)
            COL_WHITE:  px_new = r_rdata | px_bit;
            COL_BLACK:  px_new = r_rdata & ~px_bit;
            default:    px_new = r_rdata ^ px_bit;
        endcase
    end

    assign t_row = 32'(r_tidx[2:0]);
    assign t_x = 32'(r_tidx >> 3) * 8 + 32'(r_byte);
    assign t_ok = (t_x < WIDTH_PX) && (t_row < PAGES);
    assign t_addr = AW'(t_row * WIDTH_PX + t_x);

    assign lim = (i_tiled_limit > MAX_TILES) ? MAX_TILES : i_tiled_limit;
    assign tiled = (r_cnt != 8'd0) && (r_cnt <= lim);
    assign tile_last = ({4'd0, r_emit} + 8'd1) == r_cnt;

    assign o_pop = (r_state == S_IDLE) && !i_q.empty;
    assign o_stat.init = r_init;

    always_comb begin
        mem_we = 1'b0;
        mem_addr = px_addr;
        mem_wdata = px_new;
        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_addr = r_addr;
                mem_wdata = 8'h00;
            end
            S_WR:  mem_we = 1'b1;
            S_TRD: mem_addr = t_addr;
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q.empty) begin
                    case (i_cmd.kind)
                        CMD_DRAW:  n_state = S_RD;
                        CMD_CLEAR: n_state = S_CLR;
                        CMD_FLUSH: n_state = r_any ? S_CNT : S_IDLE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR:    n_state = (r_addr == AW'(FB_BYTES - 1)) ? S_IDLE : S_CLR;
            S_RD:     n_state = S_WR;
            S_WR:     n_state = (r_cur == r_cmd.stop) ? S_IDLE : S_RD;
            S_CNT:    n_state = (r_ccol == CCW'(TILE_COLS - 1)) ? S_DECIDE : S_CNT;
            S_DECIDE: n_state = tiled ? S_TSCAN : S_IDLE;
            S_TSCAN:  n_state = r_scan[0] ? S_TRD : S_TSCAN;
            S_TRD:    n_state = (r_byte == 4'd8) ? S_TEMIT : S_TRD;
            S_TEMIT:  n_state = tile_last ? S_IDLE : S_TSCAN;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_valid = 1'b0;
        n_kind = KIND_STATUS;
        n_status = ST_OK;
        n_col = 4'd0;
        n_row = 3'd0;
        n_data = 64'd0;
        n_last = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q.empty && i_cmd.kind != CMD_DRAW
                        && !(i_cmd.kind == CMD_FLUSH && r_any)) begin
                    n_valid = 1'b1;
                    n_status = i_cmd.status;
                end
            end
            S_WR:     n_valid = (r_cur == r_cmd.stop);
            S_DECIDE: begin
                if (!tiled) begin
                    n_valid = 1'b1;
                    n_kind = KIND_FULL;
                end
            end
            S_TEMIT: begin
                n_valid = 1'b1;
                n_kind = KIND_TILE;
                n_col = 4'(r_tidx >> 3);
                n_row = r_tidx[2:0];
                n_data = r_tile;
                n_last = tile_last;
            end
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr <= '0;
            r_init <= 1'b1;
            r_dirty <= '0;
            r_any <= 1'b1;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= n_valid;
            case (r_state)
                S_IDLE: begin
                    if (!i_q.empty) begin
                        if (i_cmd.kind == CMD_CLEAR) begin
                            r_dirty <= '1;
                            r_any <= 1'b1;
                            r_addr <= '0;
                        end else if (i_cmd.kind == CMD_RECT) begin
                            r_dirty <= r_dirty | mark_mask(i_cmd.c0, i_cmd.c1, i_cmd.r0, i_cmd.r1);
                            r_any <= r_any | (|mark_mask(i_cmd.c0, i_cmd.c1, i_cmd.r0, i_cmd.r1));
                        end
                    end
                end
                S_CLR: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(FB_BYTES - 1)) begin
                        r_init <= 1'b0;
                    end
                end
                S_WR: begin
                    r_dirty <= r_dirty | mark_mask(px_x[7:3], px_x[7:3], px_y[7:3], px_y[7:3]);
                    r_any <= r_any | (|mark_mask(px_x[7:3], px_x[7:3], px_y[7:3], px_y[7:3]));
                end
                S_DECIDE: begin
                    if (!tiled) begin
                        r_dirty <= '0;
                        r_any <= 1'b0;
                    end
                end
                S_TEMIT: begin
                    if (tile_last) begin
                        r_dirty <= '0;
                        r_any <= 1'b0;
                    end
                end
                default: r_any <= r_any;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        o_kind <= n_kind;
        o_status <= n_status;
        o_tile_col <= n_col;
        o_tile_row <= n_row;
        o_tile_data <= n_data;
        o_last <= n_last;
        case (r_state)
            S_IDLE: begin
                r_cmd <= i_cmd;
                r_cur <= i_cmd.start;
                r_scan <= r_dirty;
                r_cnt <= 8'd0;
                r_ccol <= '0;
            end
            S_WR:  r_cur <= r_cur + 8'd1;
            S_CNT: begin
                r_cnt <= r_cnt + 8'($countones(r_scan[7:0]));
                r_scan <= r_scan >> 8;
                r_ccol <= r_ccol + CCW'(1);
            end
            S_DECIDE: begin
                r_scan <= r_dirty;
                r_tidx <= '0;
                r_emit <= 4'd0;
            end
            S_TSCAN: begin
                r_byte <= 4'd0;
                if (!r_scan[0]) begin
                    r_scan <= r_scan >> 1;
                    r_tidx <= r_tidx + TW'(1);
                end
            end
            S_TRD: begin
                r_byte <= r_byte + 4'd1;
                r_prev_ok <= t_ok;
                if (r_byte != 4'd0) begin
                    r_tile <= {r_prev_ok ? r_rdata : 8'h00, r_tile[63:8]};
                end
            end
            S_TEMIT: begin
                r_scan <= r_scan >> 1;
                r_tidx <= r_tidx + TW'(1);
                r_emit <= r_emit + 4'd1;
            end
            default: r_cur <= r_cur;
        endcase
    end

endmodule

// ----- src/pfdt_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the result stream, bound to the top level.
// Depends on pfdt_pkg and page_framebuffer_dirty_tiles_macros.svh.
`include "page_framebuffer_dirty_tiles_macros.svh"
module pfdt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic [1:0]  o_kind,
    input logic [1:0]  o_status,
    input logic [3:0]  o_tile_col,
    input logic [2:0]  o_tile_row,
    input logic [63:0] o_tile_data,
    input logic        o_last
);
    import pfdt_pkg::*;

    `PFDT_ASSERT_IMP(a_single_last, o_valid && o_kind != KIND_TILE, o_last, "lone word without last")
    `PFDT_ASSERT_IMP(a_no_payload, o_valid && o_kind != KIND_TILE, o_tile_data == 64'd0 && o_tile_col == 4'd0 && o_tile_row == 3'd0, "payload on non-tile word")
    `PFDT_ASSERT_IMP(a_push_ok, o_valid && o_kind != KIND_STATUS, o_status == ST_OK, "push word with error status")
    `PFDT_ASSERT_NXT(a_tile_gap, o_valid && o_kind == KIND_TILE && !o_last, !o_valid, "tile words without gap")

endmodule

bind page_framebuffer_dirty_tiles pfdt_checker u_pfdt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .o_kind(o_kind),
    .o_status(o_status), .o_tile_col(o_tile_col), .o_tile_row(o_tile_row),
    .o_tile_data(o_tile_data), .o_last(o_last)
);
